@@ hdl/hsdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsdc_pkg: shared types and constants for the heater slot duty controller
// Field widths, register indexes and the duty arithmetic constants.
// ----------------------------------------------------------------------------
package hsdc_pkg;

    localparam int COUNT_BITS = 16;
    localparam int PROD_BITS  = COUNT_BITS + 7;
    localparam int TEMP_BITS  = 12;
    localparam int TGT_BITS   = 11;
    localparam int DUTY_BITS  = 7;
    localparam int ERR_BITS   = 13;
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;

    localparam logic [DUTY_BITS-1:0] DUTY_OFF  = 7'd0;
    localparam logic [DUTY_BITS-1:0] DUTY_FULL = 7'd100;
    localparam logic [DUTY_BITS-1:0] DUTY_MOD  = 7'd101;
    localparam logic [DUTY_BITS-1:0] DUTY_STEP = 7'd10;
    localparam logic signed [ERR_BITS-1:0] ERR_SAT = 13'sd10;

    typedef enum logic [1:0] {
        REG_AUTO_MODE   = 2'd0,
        REG_TARGET_TEMP = 2'd1,
        REG_MANUAL_DUTY = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                 auto_mode;
        logic [TGT_BITS-1:0]  target_temp;
        logic [DUTY_BITS-1:0] manual_duty;
    } t_cfg;

    typedef struct packed {
        logic                        slot_tick;
        logic signed [TEMP_BITS-1:0] temperature;
        logic                        read_error;
    } t_item;

    typedef struct packed {
        logic                 heater_on;
        logic [DUTY_BITS-1:0] duty_now;
    } t_result;

endpackage
`default_nettype wire

@@ hdl/hsdc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsdc_in_if / hsdc_out_if: valid/ready channels of the duty controller
// Input channel carries one loop pass, output channel one result.
// ----------------------------------------------------------------------------
interface hsdc_in_if import hsdc_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic                        slot_tick;
    logic signed [TEMP_BITS-1:0] temperature;
    logic                        read_error;

    modport source (output valid, slot_tick, temperature, read_error, input ready);
    modport sink   (input valid, slot_tick, temperature, read_error, output ready);
endinterface

interface hsdc_out_if import hsdc_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 heater_on;
    logic [DUTY_BITS-1:0] duty_now;

    modport source (output valid, heater_on, duty_now, input ready);
    modport sink   (input valid, heater_on, duty_now, output ready);
endinterface
`default_nettype wire

@@ hdl/hsdc_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsdc_regs: APB configuration registers
// Holds auto mode, target temperature and manual duty.
// ----------------------------------------------------------------------------
module hsdc_regs import hsdc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready,
    output t_cfg                      o_cfg
);

    logic                 r_auto_mode;
    logic [TGT_BITS-1:0]  r_target_temp;
    logic [DUTY_BITS-1:0] r_manual_duty;
    logic                 w_wr;
    t_reg_idx             w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_mode   <= 1'b0;
            r_target_temp <= '0;
            r_manual_duty <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_AUTO_MODE:   r_auto_mode   <= pwdata[0];
                REG_TARGET_TEMP: r_target_temp <= pwdata[TGT_BITS-1:0];
                REG_MANUAL_DUTY: r_manual_duty <= pwdata[DUTY_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_AUTO_MODE:   prdata = DATA_BITS'(r_auto_mode);
            REG_TARGET_TEMP: prdata = DATA_BITS'(r_target_temp);
            REG_MANUAL_DUTY: prdata = DATA_BITS'(r_manual_duty);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = '{auto_mode: r_auto_mode, target_temp: r_target_temp,
                     manual_duty: r_manual_duty};

endmodule
`default_nettype wire

@@ hdl/hsdc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsdc_core: slot counters, heater level and duty selection
// Applies one pass per step; presents the result of that pass.
// ----------------------------------------------------------------------------
module hsdc_core import hsdc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  t_item     i_item,
    input  t_cfg      i_cfg,
    output t_result   o_result
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [DUTY_BITS-1:0]  r_duty;
    logic [COUNT_BITS-1:0] r_total;
    logic [COUNT_BITS-1:0] r_heated;
    logic                  r_level;
    logic [DUTY_BITS-1:0]  n_duty;
    logic [COUNT_BITS-1:0] n_total;
    logic [COUNT_BITS-1:0] n_heated;
    logic                  n_level;

    logic                  w_restart;
    logic [COUNT_BITS-1:0] w_total_inc;
    logic [COUNT_BITS-1:0] w_heated_base;
    logic [PROD_BITS-1:0]  w_lhs;
    logic [PROD_BITS-1:0]  w_rhs;
    logic                  w_heat;
    logic signed [ERR_BITS-1:0] w_err;
    logic [DUTY_BITS-1:0]  w_auto_duty;
    logic [DUTY_BITS-1:0]  w_man_duty;

    // slot decision: restart counters at full scale, then count this slot
    assign w_restart     = (r_total == COUNT_MAX);
    assign w_total_inc   = w_restart ? COUNT_BITS'(1) : r_total + COUNT_BITS'(1);
    assign w_heated_base = (w_restart || r_total == '0) ? '0 : r_heated;
    assign w_lhs  = PROD_BITS'(w_heated_base) * PROD_BITS'(DUTY_FULL);
    assign w_rhs  = PROD_BITS'(r_duty) * PROD_BITS'(w_total_inc);
    assign w_heat = (w_heated_base == '0) || (w_lhs <= w_rhs);

    // duty selection
    assign w_err = $signed({2'b00, i_cfg.target_temp})
                 - $signed({i_item.temperature[TEMP_BITS-1], i_item.temperature});

    always_comb begin
        if (i_item.read_error || w_err < 0) begin
            w_auto_duty = DUTY_OFF;
        end else if (w_err > ERR_SAT) begin
            w_auto_duty = DUTY_FULL;
        end else begin
            w_auto_duty = DUTY_BITS'(w_err[3:0]) * DUTY_STEP;
        end
    end

    assign w_man_duty = (i_cfg.manual_duty >= DUTY_MOD) ? i_cfg.manual_duty - DUTY_MOD
                                                        : i_cfg.manual_duty;

    always_comb begin
        n_total  = r_total;
        n_heated = r_heated;
        n_level  = r_level;
        if (i_item.slot_tick) begin
            if (r_duty == DUTY_OFF) begin
                n_level = 1'b0;
            end else if (r_duty == DUTY_FULL) begin
                n_level = 1'b1;
            end else begin
                n_total  = w_total_inc;
                n_heated = w_heated_base + COUNT_BITS'(w_heat);
                n_level  = w_heat;
            end
        end
        n_duty = i_cfg.auto_mode ? w_auto_duty : w_man_duty;
        if (n_duty != r_duty) begin
            n_total  = '0;
            n_heated = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty   <= '0;
            r_total  <= '0;
            r_heated <= '0;
            r_level  <= 1'b0;
        end else if (i_step) begin
            r_duty   <= n_duty;
            r_total  <= n_total;
            r_heated <= n_heated;
            r_level  <= n_level;
        end
    end

    assign o_result = '{heater_on: n_level, duty_now: n_duty};

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_duty <= DUTY_FULL) else $error("duty above full scale");

    a_heated_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heated <= r_total) else $error("heated slots exceed total slots");

    a_off_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.slot_tick && r_duty == DUTY_OFF) |=> !r_level)
        else $error("heater on at zero duty");

    a_change_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_duty != r_duty) |=> (r_total == '0 && r_heated == '0))
        else $error("duty change left counters running");

endmodule
`default_nettype wire

@@ hdl/heater_slot_duty_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heater_slot_duty_controller: time-proportional heater drive
// Input register, one-pass duty/slot logic, registered result.
// ----------------------------------------------------------------------------
// One transaction on the input channel is one control loop pass. It is held
// in an input register; when it advances, the slot logic updates the heater
// level (on a slot tick), picks the duty for later passes, and the result
// lands in the output register. A pass can be accepted every clock while the
// output does not stall: the input register refills in the same cycle it
// hands its pass on, so throughput is one transaction per cycle. Output valid
// is registered and rises as the pass enters the output register. The
// critical path is one 23-bit compare of two small products (heated*100
// against duty*total). Output back pressure stalls the output register, then
// the input register, then the input channel. The user must write the
// configuration registers (APB, byte addresses 0, 4, 8) only while no pass
// is in flight; the block does not enforce it. Reads return the stored value.
// ----------------------------------------------------------------------------
module heater_slot_duty_controller import hsdc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    hsdc_in_if.sink                   in_if,
    hsdc_out_if.source                out_if,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready
);

    t_cfg    w_cfg;
    t_result w_result;
    logic    w_advance;
    logic    w_accept;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;

    hsdc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // advance the held pass whenever the output register is free or draining
    assign w_advance   = r_in_valid && (!r_out_valid || out_if.ready);
    assign in_if.ready = !r_in_valid || w_advance;
    assign w_accept    = in_if.valid && in_if.ready;

    hsdc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // capture the incoming pass; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= '{slot_tick: in_if.slot_tick, temperature: in_if.temperature,
                        read_error: in_if.read_error};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (out_if.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign out_if.valid     = r_out_valid;
    assign out_if.heater_on = r_result.heater_on;
    assign out_if.duty_now  = r_result.duty_now;

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid) else $error("advanced pass lost");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !out_if.ready) |-> !w_advance)
        else $error("pending result overwritten");

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the heater slot duty controller
// Sends control loop passes through the valid/ready input channel and
// programs the controller over APB. Every accepted pass runs through an
// in-bench copy of the duty and slot logic. Each result on the output
// channel is checked field by field against the oldest predicted result.
// ---------------------------------------------------------------------------
module tb_top;
    import hsdc_pkg::*;

    localparam int IDLE_PCT      = 24;
    localparam int PRINT_CAP     = 40;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_PASSES  = 148;
    localparam int CALM_PHASE    = 4;       // phase run with both sides never idling
    localparam int TEMP_MIN      = -256;
    localparam int TEMP_MAX      = 2047;
    localparam int TGT_MAX       = 2047;
    localparam int MANUAL_MAX    = 127;     // full 7-bit register span
    localparam int WRAP_DUTY     = 37;
    localparam int SETTLE_PASSES = 60;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [DATA_BITS-1:0] pwdata  = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    hsdc_in_if  in_ch ();
    hsdc_out_if out_ch ();

    heater_slot_duty_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_if   (in_ch),
        .out_if  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // Register copies as the bench last programmed them.
    logic                  cfg_auto;
    logic [TGT_BITS-1:0]   cfg_target;
    logic [DUTY_BITS-1:0]  cfg_manual;

    // Controller state as the bench predicts it.
    logic [DUTY_BITS-1:0]  duty_in_force;
    logic [COUNT_BITS-1:0] slots_total;
    logic [COUNT_BITS-1:0] slots_heated;
    logic                  heater_level;

    t_result heater_results_due[$];

    int n_errors;
    int n_passes;
    int n_ticks;
    int n_results;
    int n_heat_on;
    int n_wraps;
    bit idle_on;
    bit stall_on;

    // -----------------------------------------------------------------------
    // Print one line per mismatch (up to a cap) and count every one.
    // -----------------------------------------------------------------------
    task automatic report_mismatch(input string what,
                                   input logic [DATA_BITS-1:0] got,
                                   input logic [DATA_BITS-1:0] want);
        n_errors++;
        if (n_errors <= PRINT_CAP) begin
            $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h",
                     $time, what, got, want);
        end
    endtask

    // -----------------------------------------------------------------------
    // Duty and slot prediction for one accepted pass.
    // A tick first updates the heater from the duty already in force, then
    // the duty for later passes is chosen; a real change clears the counters.
    // -----------------------------------------------------------------------
    function automatic void advance_heater_model(input t_item pass);
        int      err;
        int      next_duty;
        bit      heat;
        t_result res;
        if (pass.slot_tick) begin
            n_ticks++;
            if (duty_in_force == DUTY_OFF) begin
                heater_level = 1'b0;
            end else if (duty_in_force == DUTY_FULL) begin
                heater_level = 1'b1;
            end else begin
                // Restart both counters when total is already saturated.
                if (&slots_total) begin
                    slots_total  = '0;
                    slots_heated = '0;
                    n_wraps++;
                end
                if (slots_total == '0) begin
                    slots_heated = '0;
                end
                slots_total = slots_total + 1'b1;
                heat = (slots_heated == '0) ||
                       (longint'(slots_heated) * 100 <=
                        longint'(duty_in_force) * longint'(slots_total));
                if (heat) begin
                    slots_heated = slots_heated + 1'b1;
                end
                heater_level = heat;
            end
        end

        if (!cfg_auto) begin
            // Manual values above full duty fold back modulo 101.
            next_duty = int'(cfg_manual) % int'(DUTY_MOD);
        end else if (pass.read_error) begin
            next_duty = int'(DUTY_OFF);
        end else begin
            err = int'(cfg_target) - int'($signed(pass.temperature));
            if (err > int'(ERR_SAT)) begin
                next_duty = int'(DUTY_FULL);
            end else if (err < 0) begin
                next_duty = int'(DUTY_OFF);
            end else begin
                next_duty = err * int'(DUTY_STEP);
            end
        end

        if (DUTY_BITS'(next_duty) != duty_in_force) begin
            slots_total   = '0;
            slots_heated  = '0;
            duty_in_force = DUTY_BITS'(next_duty);
        end

        res.heater_on = heater_level;
        res.duty_now  = duty_in_force;
        heater_results_due.push_back(res);
    endfunction

    // -----------------------------------------------------------------------
    // Input channel: hold valid low for random gaps, then present the pass
    // and hold it until the transaction completes.
    // -----------------------------------------------------------------------
    task automatic send_pass(input logic tick, input int temp, input logic rerr);
        t_item pass;
        pass.slot_tick   = tick;
        pass.temperature = TEMP_BITS'(temp);
        pass.read_error  = rerr;
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.slot_tick   <= pass.slot_tick;
        in_ch.temperature <= pass.temperature;
        in_ch.read_error  <= pass.read_error;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        n_passes++;
        advance_heater_model(pass);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (heater_results_due.size() != 0) begin
            @(negedge i_clk);
        end
        // Allow for the pipeline to settle.
        repeat (4) @(negedge i_clk);
    endtask

    // -----------------------------------------------------------------------
    // APB access: setup cycle, then access cycle until pready.
    // -----------------------------------------------------------------------
    task automatic apb_write(input t_reg_idx idx, input logic [DATA_BITS-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(idx) << 2;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(input t_reg_idx idx, input logic [DATA_BITS-1:0] want);
        logic [DATA_BITS-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_BITS'(idx) << 2;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            report_mismatch($sformatf("register %s readback", idx.name()), got, want);
        end
    endtask

    // Write all three registers while idle, mirror them, read them back.
    task automatic program_controller(input logic auto_on,
                                      input logic [TGT_BITS-1:0] target,
                                      input logic [DUTY_BITS-1:0] manual);
        wait_drained();
        apb_write(REG_AUTO_MODE, DATA_BITS'(auto_on));
        apb_write(REG_TARGET_TEMP, DATA_BITS'(target));
        apb_write(REG_MANUAL_DUTY, DATA_BITS'(manual));
        cfg_auto   = auto_on;
        cfg_target = target;
        cfg_manual = manual;
        check_register(REG_AUTO_MODE, DATA_BITS'(auto_on));
        check_register(REG_TARGET_TEMP, DATA_BITS'(target));
        check_register(REG_MANUAL_DUTY, DATA_BITS'(manual));
    endtask

    // -----------------------------------------------------------------------
    // Output channel: stall ready at random, check every transaction.
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && !(stall_on && $urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (heater_results_due.size() == 0) begin
                report_mismatch("result with nothing pending",
                                DATA_BITS'({out_ch.heater_on, out_ch.duty_now}), '0);
            end else begin
                want = heater_results_due.pop_front();
                if (out_ch.heater_on !== want.heater_on) begin
                    report_mismatch("heater_on", DATA_BITS'(out_ch.heater_on),
                                    DATA_BITS'(want.heater_on));
                end
                if (out_ch.duty_now !== want.duty_now) begin
                    report_mismatch("duty_now", DATA_BITS'(out_ch.duty_now),
                                    DATA_BITS'(want.duty_now));
                end
                if (out_ch.heater_on === 1'b1) begin
                    n_heat_on++;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Registers read zero after reset; duty zero keeps the heater off.
    task automatic test_power_up();
        check_register(REG_AUTO_MODE, '0);
        check_register(REG_TARGET_TEMP, '0);
        check_register(REG_MANUAL_DUTY, '0);
        send_pass(1'b1, 25, 1'b0);
        send_pass(1'b0, TEMP_MIN, 1'b0);
    endtask

    // Manual duty: full, folded values above full, lowest and highest partial.
    task automatic test_manual_duty();
        program_controller(1'b0, '0, DUTY_FULL);
        repeat (2) send_pass(1'b1, 0, 1'b0);
        // 127 folds to 26
        program_controller(1'b0, '0, 7'd127);
        repeat (3) send_pass(1'b1, TEMP_MAX, 1'b0);
        // 101 folds to off
        program_controller(1'b0, '0, 7'd101);
        send_pass(1'b1, 0, 1'b1);
        program_controller(1'b0, '0, 7'd1);
        repeat (3) send_pass(1'b1, 0, 1'b0);
        program_controller(1'b0, '0, 7'd99);
        repeat (2) send_pass(1'b1, 0, 1'b0);
    endtask

    // Auto duty: zero error, error at and just above the saturation point,
    // largest error, read error, negative error, and a held duty.
    task automatic test_auto_duty();
        program_controller(1'b1, TGT_BITS'(TGT_MAX), '0);
        send_pass(1'b1, TEMP_MAX, 1'b0);
        send_pass(1'b1, TEMP_MAX - 10, 1'b0);
        send_pass(1'b1, TEMP_MAX - 11, 1'b0);
        send_pass(1'b1, TEMP_MIN, 1'b0);
        send_pass(1'b1, TEMP_MAX, 1'b1);
        program_controller(1'b1, '0, '0);
        send_pass(1'b1, 1, 1'b0);
        send_pass(1'b1, -5, 1'b0);
        // same duty again must not clear the slot counters
        send_pass(1'b1, -5, 1'b0);
        send_pass(1'b1, -5, 1'b1);
        send_pass(1'b0, TEMP_MIN, 1'b0);
    endtask

    // Run one partial duty over a long run of ticks so the heated/total
    // ratio settles around the duty.
    task automatic test_counter_wrap();
        int k;
        program_controller(1'b0, '0, DUTY_BITS'(WRAP_DUTY));
        for (k = 0; k < SETTLE_PASSES; k++) begin
            send_pass(1'b1, int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN,
                      1'($urandom_range(1)));
        end
    endtask

    // Random phases, each with its own register setting. Most passes hold a
    // temperature near the target for a run so the slot counters get deep;
    // the rest are fully random noise.
    task automatic test_random_passes();
        int ph;
        int sent;
        int run_len;
        int k;
        int base;
        bit noisy;
        logic [TGT_BITS-1:0]  target;
        logic [DUTY_BITS-1:0] manual;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(3))
                0:       target = '0;
                1:       target = TGT_BITS'(TGT_MAX);
                default: target = TGT_BITS'($urandom_range(0, TGT_MAX));
            endcase
            if (ph == 0) target = '0;
            if (ph == 1) target = TGT_BITS'(TGT_MAX);
            case ($urandom_range(4))
                0:       manual = DUTY_OFF;
                1:       manual = DUTY_FULL;
                2:       manual = DUTY_BITS'(MANUAL_MAX);
                default: manual = DUTY_BITS'($urandom_range(0, MANUAL_MAX));
            endcase
            program_controller(1'((ph % 3) != 2), target, manual);
            // One phase with no idling on either side.
            idle_on  = (ph != CALM_PHASE);
            stall_on = (ph != CALM_PHASE);
            sent = 0;
            while (sent < PHASE_PASSES) begin
                run_len = $urandom_range(8, 40);
                noisy   = ($urandom_range(99) < 15);
                base    = int'(target) - (int'($urandom_range(0, 14)) - 2);
                if (base > TEMP_MAX) base = TEMP_MAX;
                for (k = 0; k < run_len && sent < PHASE_PASSES; k++) begin
                    if (noisy) begin
                        send_pass(1'($urandom_range(1)),
                                  int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN,
                                  1'($urandom_range(1)));
                    end else begin
                        send_pass(1'($urandom_range(99) < 60), base,
                                  1'($urandom_range(99) < 5));
                    end
                    sent++;
                end
            end
        end
        idle_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial begin
        in_ch.valid       = 1'b0;
        in_ch.slot_tick   = 1'b0;
        in_ch.temperature = '0;
        in_ch.read_error  = 1'b0;
        out_ch.ready      = 1'b0;
        cfg_auto          = 1'b0;
        cfg_target        = '0;
        cfg_manual        = '0;
        duty_in_force     = DUTY_OFF;
        slots_total       = '0;
        slots_heated      = '0;
        heater_level      = 1'b0;
        idle_on           = 1'b1;
        stall_on          = 1'b1;

        // Hold reset, then release it on a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_up();
        test_manual_duty();
        test_auto_duty();
        test_counter_wrap();
        test_random_passes();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (heater_results_due.size() != 0) begin
            report_mismatch("results never delivered",
                            DATA_BITS'(heater_results_due.size()), '0);
        end

        $display("Run covered %0d passes (%0d slot ticks) and %0d results, heater on in %0d",
                 n_passes, n_ticks, n_results, n_heat_on);
        $display("Slot counters wrapped %0d times; %0d mismatches seen", n_wraps, n_errors);
        if (n_errors == 0) begin
            $display("** heater_slot_duty_controller: PASSED **");
        end else begin
            $display("** heater_slot_duty_controller: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #40_000_000;
        $display("Timeout with %0d results still pending", heater_results_due.size());
        $display("** heater_slot_duty_controller: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/hsdc_pkg.sv
hdl/hsdc_if.sv
hdl/hsdc_regs.sv
hdl/hsdc_core.sv
hdl/heater_slot_duty_controller.sv
bench/tb_top.sv
